// ----- hw/rtl/backslash_escape_encoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the backslash escape encoder
// Shared concurrent assertion forms. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_ENCODER_UNIT_MACROS_SVH
`define BACKSLASH_ESCAPE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BSESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BSESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bsesc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsesc_pkg
// Types, constants and helpers shared by the escape encoder modules.
// ----------------------------------------------------------------------------
package bsesc_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 13;

  // Default capacity limit
  localparam int unsigned MAX_CAPACITY_DEF = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DBCS_MODE     = 1'd1;

  // Register reset values
  localparam logic [CNT_W-1:0] DEST_CAPACITY_RST = 13'd4096;
  localparam logic             DBCS_MODE_RST     = 1'b1;

  // Result queue geometry
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_CW    = 3;

  // Characters
  localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_BAR  = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_BSL  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_N    = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_C    = 8'h63;
  localparam logic [BYTE_W-1:0] CH_Z    = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_Y    = 8'h79;
  localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] LEAD_MASK = 8'h80;

  // Live configuration
  typedef struct packed {
    logic [CNT_W-1:0] cap;
    logic             dbcs;
  } cfg_t;

  // Up to two results produced by one item
  typedef struct packed {
    logic [1:0]        n;
    logic [BYTE_W-1:0] b0;
    logic              l0;
    logic [BYTE_W-1:0] b1;
    logic              l1;
  } res_pair_t;

  // Escape letter for a byte, zero when the byte passes through
  function automatic logic [BYTE_W-1:0] esc_code(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    unique case (b)
      CH_NL:    c = CH_N;
      CH_COMMA: c = CH_C;
      CH_BAR:   c = CH_Z;
      CH_BSL:   c = CH_Y;
      default:  c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/backslash_escape_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// backslash_escape_encoder_unit
// Encodes a string one byte per item: newline, comma, bar and backslash become
// a backslash and 'n', 'c', 'z' or 'y'; other bytes pass. Bytes are counted
// against dest_capacity (terminator reserved); once the room runs out later
// bytes are dropped until the end item, which emits a zero byte marked last.
// In double-byte mode a lead byte (top bit set) and its trail go out as an
// unescaped pair. One item is taken per cycle while each yields one result
// and the output is not stalled; an escaped byte or an end item after a lead
// yields two results, which the single-result output port emits one at a
// time. A result passes through the input register and then the result
// queue before it is presented. Configuration writes are always ready and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module backslash_escape_encoder_unit #(
  parameter int unsigned MAX_CAPACITY = bsesc_pkg::MAX_CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bsesc_pkg::BYTE_W-1:0]    in_byte,
  input  logic                            in_end_of_string,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bsesc_pkg::BYTE_W-1:0]    out_byte,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsesc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsesc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bsesc_pkg::*;

  logic [CNT_W-1:0] dest_capacity_r;
  logic             dbcs_mode_r;
  cfg_t             cfg;
  res_pair_t        res;
  logic             room;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_capacity_r <= DEST_CAPACITY_RST;
      dbcs_mode_r     <= DBCS_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEST_CAPACITY: dest_capacity_r <= cfg_data[CNT_W-1:0];
        REG_DBCS_MODE:     dbcs_mode_r     <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  assign cfg.cap  = dest_capacity_r;
  assign cfg.dbcs = dbcs_mode_r;

  bsesc_encode #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_encode (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_string(in_end_of_string),
    .cfg             (cfg),
    .room            (room),
    .res             (res)
  );

  bsesc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// ----- hw/rtl/bsesc_encode.sv -----
// ----------------------------------------------------------------------------
// bsesc_encode
// Input register, string state and the per-item escape decision.
// ----------------------------------------------------------------------------
module bsesc_encode #(
  parameter int unsigned MAX_CAPACITY = bsesc_pkg::MAX_CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bsesc_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_end_of_string,
  input  bsesc_pkg::cfg_t            cfg,
  input  logic                       room,
  output bsesc_pkg::res_pair_t       res
);
  import bsesc_pkg::*;

  localparam int unsigned CAP_LIM = (MAX_CAPACITY < 8191) ? MAX_CAPACITY : 8191;
  localparam logic [CNT_W-1:0] CAP_LIM_V = CNT_W'(CAP_LIM);

  logic              in_v_r, in_v_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_eos_r;
  logic              accept, fire;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              trail_r, trail_nxt;
  logic              stop_r, stop_nxt;

  logic [CNT_W-1:0]  cap;
  logic [CNT_W:0]    sum1, sum2;
  logic [BYTE_W-1:0] code;
  res_pair_t         pr;

  // Input register handshake
  assign in_stall = in_v_r & ~room;
  assign accept   = in_valid & ~in_stall;
  assign fire     = in_v_r & room;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte;
      in_eos_r  <= in_end_of_string;
    end
  end

  // Saturated capacity and fit checks
  assign cap  = (cfg.cap > CAP_LIM_V) ? CAP_LIM_V : cfg.cap;
  assign sum1 = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign sum2 = {1'b0, cnt_r} + (CNT_W+1)'(2);
  assign code = esc_code(in_byte_r);

  // Escape decision for the registered item
  always_comb begin
    pr        = '0;
    cnt_nxt   = cnt_r;
    trail_nxt = trail_r;
    stop_nxt  = stop_r;
    priority if (in_eos_r) begin
      if (trail_r) begin
        pr.n  = 2'd2;
        pr.b0 = CH_NUL;
        pr.l0 = 1'b0;
        pr.b1 = CH_NUL;
        pr.l1 = 1'b1;
      end else begin
        pr.n  = 2'd1;
        pr.b0 = CH_NUL;
        pr.l0 = 1'b1;
      end
      cnt_nxt   = '0;
      trail_nxt = 1'b0;
      stop_nxt  = 1'b0;
    end else if (trail_r) begin
      pr.n      = 2'd1;
      pr.b0     = in_byte_r;
      trail_nxt = 1'b0;
    end else if (stop_r) begin
      pr.n = 2'd0;
    end else if (sum1 >= {1'b0, cap}) begin
      stop_nxt = 1'b1;
    end else if (cfg.dbcs && ((in_byte_r & LEAD_MASK) != '0)) begin
      // lead byte: reserve room for the pair
      if (sum2 >= {1'b0, cap}) begin
        stop_nxt = 1'b1;
      end else begin
        pr.n      = 2'd1;
        pr.b0     = in_byte_r;
        cnt_nxt   = sum2[CNT_W-1:0];
        trail_nxt = 1'b1;
      end
    end else if (code != CH_NUL) begin
      if (sum2 < {1'b0, cap}) begin
        pr.n    = 2'd2;
        pr.b0   = CH_BSL;
        pr.b1   = code;
        cnt_nxt = sum2[CNT_W-1:0];
      end else begin
        stop_nxt = 1'b1;
      end
    end else begin
      pr.n    = 2'd1;
      pr.b0   = in_byte_r;
      cnt_nxt = sum1[CNT_W-1:0];
    end
  end

  // String state advances only when the item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      trail_r <= 1'b0;
      stop_r  <= 1'b0;
    end else if (fire) begin
      cnt_r   <= cnt_nxt;
      trail_r <= trail_nxt;
      stop_r  <= stop_nxt;
    end
  end

  always_comb begin
    res = pr;
    if (!fire) begin
      res.n = 2'd0;
    end
  end

endmodule

// ----- hw/rtl/bsesc_outq.sv -----
// ----------------------------------------------------------------------------
// bsesc_outq
// Four-entry result queue: takes up to two results a cycle, emits one unless stalled.
// ----------------------------------------------------------------------------
module bsesc_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsesc_pkg::res_pair_t         res,
  output logic                         room,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bsesc_pkg::BYTE_W-1:0] out_byte,
  output logic                         out_last
);
  import bsesc_pkg::*;

  logic [BYTE_W-1:0] byte_q [OQ_DEPTH];
  logic              last_q [OQ_DEPTH];
  logic [OQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0]  count_r, count_nxt;
  logic [OQ_AW-1:0]  wr_ptr_p1;
  logic              pop;

  // Room for a full pair
  assign room      = (count_r <= OQ_CW'(OQ_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid & ~out_stall;
  assign out_byte  = byte_q[rd_ptr_r];
  assign out_last  = last_q[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + OQ_AW'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_AW'(res.n);
    rd_ptr_nxt = rd_ptr_r + OQ_AW'(pop);
    count_nxt  = count_r + OQ_CW'(res.n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (res.n != 2'd0) begin
      byte_q[wr_ptr_r] <= res.b0;
      last_q[wr_ptr_r] <= res.l0;
    end
    if (res.n == 2'd2) begin
      byte_q[wr_ptr_p1] <= res.b1;
      last_q[wr_ptr_p1] <= res.l1;
    end
  end

endmodule

// ----- hw/rtl/bsesc_checker.sv -----
// ----------------------------------------------------------------------------
// bsesc_checker
// Port-level checks for the escape encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "backslash_escape_encoder_unit_macros.svh"

module bsesc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bsesc_pkg::BYTE_W-1:0] out_byte,
  input logic                         out_last
);
  import bsesc_pkg::*;

  // A held result keeps its payload
  `BSESC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_last), "stalled item changed")

  // The terminator is always a zero byte
  `BSESC_ASSERT_IMP(a_last_zero, out_valid && out_last, out_byte == CH_NUL, "terminator not zero")

  // With the result side empty the input side has room
  `BSESC_ASSERT_IMP(a_idle_no_stall, !out_valid, !in_stall, "input stalled while output empty")

  // Nothing comes out right after reset
  `BSESC_ASSERT_IMP(a_rst_empty, !$past(rst_n), !out_valid, "item present after reset")

endmodule

bind backslash_escape_encoder_unit bsesc_checker u_bsesc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_byte (out_byte),
  .out_last (out_last)
);

// ----- tb/backslash_escape_encoder_unit_test.sv -----
// ----------------------------------------------------------------------------
// Backslash escape encoder testbench
// Sends strings one byte per item and checks every encoded byte against typed
// or in-bench encoder bytes. A short scripted run covers each escape, lead/trail
// pairs, a missing trail, capacity stops and both modes. Random strings follow
// under many capacity and mode settings, then one long string under an oversized
// capacity. The sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module backslash_escape_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsesc_pkg::*;

  localparam int unsigned MAX_CAP       = MAX_CAPACITY_DEF;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned LONG_ITEMS    = 350;
  // about 1.7k items at two results each behind heavy stalls stays far below this
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {ROW_BYTE, ROW_END, ROW_CAP, ROW_MODE} row_kind_t;

  // One scripted step: an item (expected bytes typed in or predicted) or a register write
  typedef struct packed {
    row_kind_t         kind;
    logic [CNT_W-1:0]  arg;
    logic              typed;
    logic [1:0]        n;
    logic [BYTE_W-1:0] e0;
    logic [BYTE_W-1:0] e1;
  } script_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } enc_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_byte = '0;
  logic                  in_end_of_string = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;

  backslash_escape_encoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Encoder state and register copies
  logic [CNT_W-1:0] cap_reg = DEST_CAPACITY_RST;
  logic             dbcs_reg = DBCS_MODE_RST;
  int unsigned      enc_count = 0;
  bit               enc_trail = 1'b0;
  bit               enc_halted = 1'b0;

  enc_byte_t   expected_stream[$];
  int unsigned sent_items = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  script_row_t script [0:32] = '{
    '{ROW_END,  13'd0,        1'b1, 2'd1, CH_NUL,   CH_NUL},  // terminator right after reset
    '{ROW_BYTE, 13'(CH_NL),    1'b1, 2'd2, CH_BSL,   CH_N},
    '{ROW_BYTE, 13'(CH_COMMA), 1'b1, 2'd2, CH_BSL,   CH_C},
    '{ROW_BYTE, 13'(CH_BAR),   1'b1, 2'd2, CH_BSL,   CH_Z},
    '{ROW_BYTE, 13'(CH_BSL),   1'b1, 2'd2, CH_BSL,   CH_Y},
    '{ROW_BYTE, 13'h00,       1'b1, 2'd1, 8'h00,    CH_NUL},
    '{ROW_BYTE, 13'hFF,       1'b1, 2'd1, 8'hFF,    CH_NUL},  // lead
    '{ROW_BYTE, 13'(CH_NL),    1'b1, 2'd1, CH_NL,    CH_NUL},  // trail goes out unescaped
    '{ROW_BYTE, 13'h80,       1'b1, 2'd1, 8'h80,    CH_NUL},  // lead
    '{ROW_END,  13'h1FF,      1'b1, 2'd2, CH_NUL,   CH_NUL},  // missing trail filled with zero
    '{ROW_MODE, 13'd0,        1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'hFF,       1'b1, 2'd1, 8'hFF,    CH_NUL},  // plain byte in single-byte mode
    '{ROW_BYTE, 13'(CH_BSL),   1'b1, 2'd2, CH_BSL,   CH_Y},
    '{ROW_END,  13'd0,        1'b1, 2'd1, CH_NUL,   CH_NUL},
    '{ROW_CAP,  13'd0,        1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'h41,       1'b1, 2'd0, CH_NUL,   CH_NUL},  // zero capacity: stop
    '{ROW_END,  13'd0,        1'b1, 2'd1, CH_NUL,   CH_NUL},  // terminator still emitted
    '{ROW_CAP,  13'd3,        1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'h41,       1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'(CH_COMMA), 1'b1, 2'd0, CH_NUL,   CH_NUL},  // escape pair does not fit
    '{ROW_BYTE, 13'h42,       1'b1, 2'd0, CH_NUL,   CH_NUL},  // dropped once stopped
    '{ROW_END,  13'd0,        1'b1, 2'd1, CH_NUL,   CH_NUL},
    '{ROW_MODE, 13'd1,        1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'h41,       1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'h90,       1'b1, 2'd0, CH_NUL,   CH_NUL},  // lead pair does not fit
    '{ROW_END,  13'd0,        1'b1, 2'd1, CH_NUL,   CH_NUL},
    '{ROW_CAP,  13'd4,        1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'hC3,       1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'(CH_BSL),   1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'h42,       1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_BYTE, 13'h43,       1'b0, 2'd0, CH_NUL,   CH_NUL},
    '{ROW_END,  13'd0,        1'b1, 2'd1, CH_NUL,   CH_NUL},
    '{ROW_CAP,  13'd4096,     1'b0, 2'd0, CH_NUL,   CH_NUL}
  };

  // Encode one item, advancing the in-bench state
  function automatic res_pair_t encode_item(input logic [BYTE_W-1:0] b, input logic eos);
    res_pair_t         r;
    int unsigned       room;
    logic [BYTE_W-1:0] letter;
    r = '0;
    room = (cap_reg > MAX_CAP) ? MAX_CAP : cap_reg;
    case (b)
      CH_NL:    letter = CH_N;
      CH_COMMA: letter = CH_C;
      CH_BAR:   letter = CH_Z;
      CH_BSL:   letter = CH_Y;
      default:  letter = CH_NUL;
    endcase
    if (eos) begin
      if (enc_trail) begin
        r.n = 2'd2; r.b0 = CH_NUL; r.b1 = CH_NUL; r.l1 = 1'b1;
      end else begin
        r.n = 2'd1; r.b0 = CH_NUL; r.l0 = 1'b1;
      end
      enc_count = 0;
      enc_trail = 1'b0;
      enc_halted = 1'b0;
    end else if (enc_trail) begin
      enc_trail = 1'b0;
      r.n = 2'd1; r.b0 = b;
    end else if (enc_halted) begin
      r.n = 2'd0;
    end else if (enc_count + 1 >= room) begin
      enc_halted = 1'b1;
    end else if (dbcs_reg && b[7]) begin
      if (enc_count + 2 >= room) begin
        enc_halted = 1'b1;
      end else begin
        enc_count += 2;
        enc_trail = 1'b1;
        r.n = 2'd1; r.b0 = b;
      end
    end else if (letter != CH_NUL) begin
      if (enc_count + 2 < room) begin
        enc_count += 2;
        r.n = 2'd2; r.b0 = CH_BSL; r.b1 = letter;
      end else begin
        enc_halted = 1'b1;
      end
    end else begin
      enc_count += 1;
      r.n = 2'd1; r.b0 = b;
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_escapable();
    case ($urandom_range(0, 3))
      0:       return CH_NL;
      1:       return CH_COMMA;
      2:       return CH_BAR;
      default: return CH_BSL;
    endcase
  endfunction

  // The wait is a do-while on the clock, so valid is never lowered and raised in one step
  task automatic wait_for_drain();
    do @(posedge clk); while (expected_stream.size() != 0);
  endtask

  // Drive one item, wait for it to be taken, then queue its expected bytes
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos,
                           input bit typed, input res_pair_t given);
    res_pair_t r;
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    r = encode_item(b, eos);
    if (typed) r = given;
    sent_items++;
    if (r.n != 2'd0) expected_stream.push_back('{r.b0, r.l0});
    if (r.n == 2'd2) expected_stream.push_back('{r.b1, r.l1});
  endtask

  // Sender bursts: either keep valid up, or drop it for a gap
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 39) == 0) wait_for_drain();
      else repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 8);
    end
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DEST_CAPACITY) cap_reg = val;
    else dbcs_reg = val[0];
  endtask

  // Random string: escapes, lead/trail pairs, noise; sometimes cut after a lead
  task automatic send_string(input int unsigned len, input bit close);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] tb_trail;
    bit                drop_trail;
    drop_trail = ($urandom_range(0, 7) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    b = pick_escapable();
        2, 3:    b = {1'b1, 7'($urandom_range(0, 127))};
        4:       b = 8'($urandom_range(0, 255));
        default: b = 8'($urandom_range(8'h20, 8'h7E));
      endcase
      send_item(b, 1'b0, 1'b0, '0);
      pace();
      if (b[7] && !(drop_trail && i == len - 1)) begin
        tb_trail = $urandom_range(0, 1) ? pick_escapable() : 8'($urandom_range(0, 255));
        send_item(tb_trail, 1'b0, 1'b0, '0);
        pace();
      end
    end
    if (close) begin
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      pace();
    end
  endtask

  // Receiver stall pattern: changes character after each randomly drawn span
  int unsigned stall_span = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(50, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 8 >= 5);
    endcase
  end

  // Output check against the oldest expected byte
  always @(posedge clk) begin : out_check
    enc_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stream.size() == 0) begin
        $display("%0t: unexpected item: byte %02h last %0b", $time, out_byte, out_last);
        mismatches++;
      end else begin
        want = expected_stream.pop_front();
        if (out_byte !== want.b) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.b, out_byte);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    res_pair_t         given;
    logic [CNT_W-1:0]  cap;
    logic [BYTE_W-1:0] b;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Scripted cases
    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CAP:  write_reg(REG_DEST_CAPACITY, script[i].arg);
        ROW_MODE: write_reg(REG_DBCS_MODE, script[i].arg);
        default: begin
          given = '0;
          given.n = script[i].n;
          given.b0 = script[i].e0;
          given.b1 = script[i].e1;
          if (script[i].kind == ROW_END) begin
            given.l0 = (script[i].n == 2'd1);
            given.l1 = (script[i].n == 2'd2);
          end
          send_item(script[i].arg[BYTE_W-1:0], script[i].kind == ROW_END,
                    script[i].typed, given);
          pace();
        end
      endcase
    end

    // Random phases; a phase may stop mid-string so the next setting applies part way
    while (sent_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       cap = 13'($urandom_range(0, 3));
        1, 2:    cap = 13'($urandom_range(4, 24));
        3:       cap = 13'($urandom_range(25, 200));
        4:       cap = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
        default: cap = 13'($urandom_range(0, 8191));
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_DEST_CAPACITY, cap);
      if ($urandom_range(0, 1) != 0) write_reg(REG_DBCS_MODE, 13'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 6)) begin
        send_string(($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 20),
                    $urandom_range(0, 5) != 0);
      end
    end

    // Oversized capacity: a long escape-heavy string runs with the capacity above the limit
    write_reg(REG_DBCS_MODE, 13'd0);
    write_reg(REG_DEST_CAPACITY, $urandom_range(0, 1) ? 13'h1FFF : 13'($urandom_range(4097, 8190)));
    for (int unsigned i = 0; i < LONG_ITEMS; i++) begin
      b = ($urandom_range(0, 3) != 0) ? pick_escapable() : 8'($urandom_range(8'h20, 8'h7E));
      send_item(b, 1'b0, 1'b0, '0);
      pace();
    end
    send_item(8'h00, 1'b1, 1'b0, '0);

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bsesc_pkg.sv
hw/rtl/bsesc_encode.sv
hw/rtl/bsesc_outq.sv
hw/rtl/backslash_escape_encoder_unit.sv
hw/rtl/bsesc_checker.sv
tb/backslash_escape_encoder_unit_test.sv
